### design/tsa_pkg.sv
package tsa_pkg;

  // field and register widths
  localparam int ANGLE_W   = 31;
  localparam int THRESH_W  = 30;
  localparam int TERMS_W   = 4;
  localparam int FRAC_BITS = 30;

  // magnitude, product and divider widths
  localparam int MAG_W    = 31;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int RECIP_W  = 29;
  localparam int DIV_W    = 11;
  localparam int RECIP_SH = 31;
  localparam int TBL_N    = 16;
  localparam int TBL_IW   = 4;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 30'd107374;

  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [PROD_W-1:0] prod_t;

  // operands handed to the shared multiplier
  typedef struct packed {
    mag_t op_a;
    mag_t op_b;
  } mul_req_t;

  // divisor (2n)(2n+1) for term n, entry n-1
  localparam logic [DIV_W-1:0] DIV_TBL [TBL_N] = '{
    11'd6,   11'd20,  11'd42,  11'd72,  11'd110, 11'd156, 11'd210, 11'd272,
    11'd342, 11'd420, 11'd506, 11'd600, 11'd702, 11'd812, 11'd930, 11'd1056
  };

  // floor(2^31 / divisor), entry n-1; quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP_TBL [TBL_N] = '{
    29'd357913941, 29'd107374182, 29'd51130563, 29'd29826161,
    29'd19522578,  29'd13765920,  29'd10226112, 29'd7895160,
    29'd6279191,   29'd5113056,   29'd4244038,  29'd3579139,
    29'd3059093,   29'd2644684,   29'd2309122,  29'd2033601
  };

endpackage

### design/tsa_if.sv
interface tsa_in_if import tsa_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface tsa_out_if import tsa_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] sine_value;
  logic [TERMS_W-1:0]        terms_used;
  logic                      term_limit_hit;

  modport source (output valid, output sine_value, output terms_used,
                  output term_limit_hit, input ready);
  modport sink   (input valid, input sine_value, input terms_used,
                  input term_limit_hit, output ready);
endinterface

### design/tsa_mul.sv
module tsa_mul import tsa_pkg::*; (
  input  logic     clk,
  input  mul_req_t req,
  output prod_t    prod_r
);

  // shared unsigned multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(req.op_a) * PROD_W'(req.op_b);
  end

endmodule

### design/taylor_sine_approximation.sv
// a new angle word is accepted only in idle, after the previous result has gone into the result register
// the sequencer waits in ST_DONE while the result register holds a word that has not been taken
// each term runs through four states: three passes through the one shared multiplier
// (product, reciprocal divide, back-multiply) and one to correct and accumulate
// reset (rst_n, synchronous, active low) idles the sequencer, empties the
// result register and sets the stop threshold thr_r to 107374
module taylor_sine_approximation import tsa_pkg::*; #(
  parameter int MAX_TERMS  = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [THRESH_W-1:0] cfg_wdata,
  tsa_in_if.sink              in_chan,
  tsa_out_if.source           out_chan
);

  localparam int NW = $clog2(MAX_TERMS + 1);
  localparam int SW = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 1;

  localparam logic signed [SW-1:0] ACC_MAX = SW'((65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1);
  localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [SW-1:0] OUT_MAX = SW'((65'sd1 <<< (ANGLE_W - 1)) - 65'sd1);
  localparam logic signed [SW-1:0] OUT_MIN = ~OUT_MAX;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_SQX  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIVM = 3'd4;
  localparam logic [2:0] ST_DIVB = 3'd5;
  localparam logic [2:0] ST_FIX  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  function automatic logic signed [DATA_WIDTH-1:0] sat_acc(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    priority if (v > ACC_MAX) c = ACC_MAX;
    else if (v < ACC_MIN)     c = ACC_MIN;
    else                      c = v;
    return c[DATA_WIDTH-1:0];
  endfunction

  logic [2:0]                    state_r, state_nxt;
  logic [THRESH_W-1:0]           thr_r;
  logic                          neg_r;
  mag_t                          tmag_r;
  mag_t                          x2_r;
  mag_t                          p_r;
  mag_t                          q_r;
  logic [NW-1:0]                 n_r;
  logic signed [DATA_WIDTH-1:0]  sum_r;
  logic                          lim_r;
  logic                          out_valid_r;
  logic signed [ANGLE_W-1:0]     out_sine_r;
  logic [TERMS_W-1:0]            out_terms_r;
  logic                          out_lim_r;

  mul_req_t                      mreq;
  prod_t                         prod_r;
  logic [TBL_IW-1:0]             tidx;
  logic [DIV_W-1:0]              div_d;
  logic [RECIP_W-1:0]            recip;
  logic [ANGLE_W-1:0]            raw;
  mag_t                          mag_in;
  logic signed [SW-1:0]          init_v;
  mag_t                          rem;
  mag_t                          q_fix;
  logic                          tneg;
  logic signed [SW-1:0]          term_v;
  logic signed [SW-1:0]          sum_ext;
  logic signed [SW-1:0]          out_c;
  logic                          met;
  logic                          last;
  logic                          in_acc;
  logic                          load_out;

  // shared multiplier
  tsa_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod_r)
  );

  // per-term constants
  assign tidx  = TBL_IW'(n_r - NW'(1));
  assign div_d = DIV_TBL[tidx];
  assign recip = RECIP_TBL[tidx];

  // input magnitude and sign
  assign raw    = in_chan.angle;
  assign mag_in = raw[ANGLE_W-1] ? MAG_W'(~raw + 1'b1) : MAG_W'(raw);
  assign init_v = raw[ANGLE_W-1] ? -SW'(mag_in) : SW'(mag_in);

  // quotient correction and term accumulate
  assign rem     = p_r - prod_r[MAG_W-1:0];
  assign q_fix   = q_r + MAG_W'(rem >= MAG_W'(div_d));
  assign tneg    = neg_r ^ n_r[0];
  assign term_v  = tneg ? -SW'(q_fix) : SW'(q_fix);
  assign sum_ext = SW'(sum_r);
  assign met     = q_fix <= MAG_W'(thr_r);
  assign last    = n_r == NW'(MAX_TERMS);

  // final saturation to the output range
  always_comb begin
    priority if (sum_ext > OUT_MAX) out_c = OUT_MAX;
    else if (sum_ext < OUT_MIN)      out_c = OUT_MIN;
    else                             out_c = sum_ext;
  end

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  // multiplier operand select
  always_comb begin
    mreq = '0;
    unique case (state_r)
      ST_SQR:  begin mreq.op_a = tmag_r;                        mreq.op_b = tmag_r; end
      ST_MUL:  begin mreq.op_a = tmag_r;                        mreq.op_b = x2_r; end
      ST_DIVM: begin mreq.op_a = prod_r[FRAC_BITS +: MAG_W];    mreq.op_b = MAG_W'(recip); end
      ST_DIVB: begin mreq.op_a = prod_r[RECIP_SH +: MAG_W];     mreq.op_b = MAG_W'(div_d); end
      ST_IDLE, ST_SQX, ST_FIX, ST_DONE: mreq = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIVM;
      ST_DIVM: state_nxt = ST_DIVB;
      ST_DIVB: state_nxt = ST_FIX;
      ST_FIX:  state_nxt = (met || last) ? ST_DONE : ST_MUL;
      ST_DONE: if (load_out) state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (in_acc) begin
        neg_r  <= raw[ANGLE_W-1];
        tmag_r <= mag_in;
        sum_r  <= sat_acc(init_v);
        n_r    <= NW'(1);
      end
      ST_SQX:  x2_r <= prod_r[FRAC_BITS +: MAG_W];
      ST_DIVM: p_r  <= prod_r[FRAC_BITS +: MAG_W];
      ST_DIVB: q_r  <= prod_r[RECIP_SH +: MAG_W];
      ST_FIX: begin
        tmag_r <= q_fix;
        sum_r  <= sat_acc(sum_ext + term_v);
        lim_r  <= !met;
        if (!(met || last)) n_r <= n_r + NW'(1);
      end
      ST_SQR, ST_MUL, ST_DONE: ;
    endcase
    if (load_out) begin
      out_sine_r  <= out_c[ANGLE_W-1:0];
      out_terms_r <= TERMS_W'(n_r);
      out_lim_r   <= lim_r;
    end
  end

  // ports
  assign in_chan.ready           = state_r == ST_IDLE;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.sine_value     = out_sine_r;
  assign out_chan.terms_used     = out_terms_r;
  assign out_chan.term_limit_hit = out_lim_r;

endmodule
